>>> src/bclru_pkg.sv
// ---------------------------------------------------------------------------
// bclru_pkg
// Types, codes and constants shared by the block cache replacement logic.
// ---------------------------------------------------------------------------
package bclru_pkg;

	localparam int DEF_NUM_BLOCKS = 1024;
	localparam int BLK_W          = 10;
	localparam int CNT_W          = 11;
	localparam int STAMP_W        = 32;

	localparam logic [1:0] KIND_READ  = 2'd0;
	localparam logic [1:0] KIND_WRITE = 2'd1;
	localparam logic [1:0] KIND_MISS  = 2'd2;
	localparam logic [1:0] KIND_BAD   = 2'd3;

	localparam logic [2:0] STAT_LOADED       = 3'd0;
	localparam logic [2:0] STAT_LOADED_EVICT = 3'd1;
	localparam logic [2:0] STAT_NOTED        = 3'd2;
	localparam logic [2:0] STAT_BAD_BLOCK    = 3'd3;
	localparam logic [2:0] STAT_RESIDENT     = 3'd4;
	localparam logic [2:0] STAT_ABSENT       = 3'd5;

	localparam logic [1:0] REG_CAPACITY = 2'd0;
	localparam logic [1:0] REG_PINNED   = 2'd1;
	localparam logic [1:0] REG_BLOCKS   = 2'd2;

	localparam logic [CNT_W-1:0] RST_CAPACITY = 11'd10;
	localparam logic [BLK_W-1:0] RST_PINNED   = 10'd1;
	localparam logic [CNT_W-1:0] RST_BLOCKS   = 11'd1024;

	typedef struct packed {
		logic [1:0]       kind;
		logic [BLK_W-1:0] block;
	} bclru_cmd_t;

	typedef struct packed {
		logic [2:0]         status;
		logic [BLK_W-1:0]   evicted_block;
		logic               evicted_dirty;
		logic [STAMP_W-1:0] miss_count;
	} bclru_result_t;

	typedef struct packed {
		logic valid;
		logic accessed;
		logic dirty;
	} bclru_marks_t;

	typedef struct packed {
		logic               cand;
		logic               dirty;
		logic [STAMP_W-1:0] key;
	} bclru_cand_t;

	typedef struct packed {
		logic found;
		logic dirty;
	} bclru_sel_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_LOOK,
		ST_SCAN,
		ST_EVICT,
		ST_LOAD
	} bclru_state_t;

endpackage

>>> src/bclru_minsel.sv
// ---------------------------------------------------------------------------
// bclru_minsel
// Running minimum over a stream of candidates; the earliest candidate fed wins ties.
// ---------------------------------------------------------------------------
module bclru_minsel #(
	parameter int IDX_W = 10
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    clear,
	input  bclru_pkg::bclru_cand_t  feed,
	input  logic [IDX_W-1:0]        feed_idx,
	output bclru_pkg::bclru_sel_t   sel,
	output logic [IDX_W-1:0]        best_idx
);
	import bclru_pkg::*;

	logic               found_q;
	logic               dirty_q;
	logic [STAMP_W-1:0] key_q;
	logic [IDX_W-1:0]   idx_q;
	logic               take;

	assign take = feed.cand && (!found_q || (feed.key < key_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
		end else if (clear) begin
			found_q <= 1'b0;
		end else if (take) begin
			found_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (take && !clear) begin
			key_q   <= feed.key;
			idx_q   <= feed_idx;
			dirty_q <= feed.dirty;
		end
	end

	assign sel.found = found_q;
	assign sel.dirty = dirty_q;
	assign best_idx  = idx_q;

endmodule

>>> src/block_cache_lru_replacer.sv
// ---------------------------------------------------------------------------
// block_cache_lru_replacer
// Replacement manager for a disk block cache with accessed-bit sampling.
// ---------------------------------------------------------------------------
// After reset the block runs a clearing pass over the mark memory with busy
// high; register writes are taken meanwhile. A read, write or rejected
// command, or a miss on a resident block, gives its result from the look
// step. A load (miss) walks every block's marks and stamp through one memory
// read port and one shared compare unit, one block per cycle, then passes
// through the evict and load steps to done. busy stays high until the done
// cycle. Each result is valid for the single cycle done is high; the
// receiver cannot stall it.
module block_cache_lru_replacer #(
	parameter int NUM_BLOCKS = bclru_pkg::DEF_NUM_BLOCKS
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  bclru_pkg::bclru_cmd_t       cmd,
	output logic                        done,
	output bclru_pkg::bclru_result_t    result,
	input  logic                        wr_en,
	input  logic [1:0]                  wr_index,
	input  logic [bclru_pkg::CNT_W-1:0] wr_data
);
	import bclru_pkg::*;

	localparam int IDX_W  = $clog2(NUM_BLOCKS);
	localparam int SCAN_W = $clog2(NUM_BLOCKS + 1);

	bclru_state_t state_q, state_d;

	logic [CNT_W-1:0]   capacity_q;
	logic [BLK_W-1:0]   pinned_q;
	logic [CNT_W-1:0]   blocks_q;

	bclru_marks_t       marks_mem [NUM_BLOCKS];
	logic [STAMP_W-1:0] stamp_mem [NUM_BLOCKS];
	bclru_marks_t       marks_rd_q;
	logic [STAMP_W-1:0] stamp_rd_q;

	logic [1:0]         kind_q;
	logic [IDX_W-1:0]   blk_q;
	logic               bad_q;
	logic [SCAN_W-1:0]  scan_q;
	logic               pv_s1;
	logic [IDX_W-1:0]   idx_s1;
	logic               ev_q;
	logic [CNT_W-1:0]   resident_q;
	logic [STAMP_W-1:0] cnt_q;

	logic               done_q;
	bclru_result_t      result_q;

	logic               accept;
	logic               bad_in;
	logic               scan_end;
	logic               clear_last;
	logic               issue;
	logic [IDX_W-1:0]   rd_addr;
	logic               mark_we;
	logic [IDX_W-1:0]   mark_addr;
	bclru_marks_t       mark_wdata;
	logic               stamp_we;
	logic [IDX_W-1:0]   stamp_addr;
	logic [STAMP_W-1:0] stamp_wdata;
	logic               touched;
	logic [STAMP_W-1:0] eff_stamp;
	logic               sel_clear;
	bclru_cand_t        feed;
	bclru_sel_t         sel;
	logic [IDX_W-1:0]   best_idx;

	assign busy       = (state_q != ST_IDLE);
	assign accept     = start && !busy;
	assign bad_in     = (cmd.kind == KIND_BAD) || ({1'b0, cmd.block} >= blocks_q)
		|| (32'(cmd.block) >= 32'(NUM_BLOCKS));
	assign scan_end   = (scan_q == SCAN_W'(NUM_BLOCKS)) && !pv_s1;
	assign clear_last = (scan_q == SCAN_W'(NUM_BLOCKS - 1));
	assign issue      = (state_q == ST_SCAN) && (scan_q != SCAN_W'(NUM_BLOCKS));
	assign touched    = marks_rd_q.valid && marks_rd_q.accessed;
	assign eff_stamp  = touched ? cnt_q : stamp_rd_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= RST_CAPACITY;
			pinned_q   <= RST_PINNED;
			blocks_q   <= RST_BLOCKS;
		end else if (wr_en) begin
			case (wr_index)
				REG_CAPACITY: capacity_q <= wr_data;
				REG_PINNED:   pinned_q   <= wr_data[BLK_W-1:0];
				REG_BLOCKS:   blocks_q   <= wr_data;
				default: ;
			endcase
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: if (clear_last) state_d = ST_IDLE;
			ST_IDLE:  if (accept) state_d = ST_LOOK;
			ST_LOOK: begin
				if (bad_q || kind_q != KIND_MISS || marks_rd_q.valid) begin
					state_d = ST_IDLE;
				end else begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN:  if (scan_end) state_d = ST_EVICT;
			ST_EVICT: state_d = ST_LOAD;
			ST_LOAD:  state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// memory and compare-unit controls
	always_comb begin
		rd_addr     = scan_q[IDX_W-1:0];
		mark_we     = 1'b0;
		mark_addr   = idx_s1;
		mark_wdata  = '0;
		stamp_we    = 1'b0;
		stamp_addr  = idx_s1;
		stamp_wdata = eff_stamp;
		sel_clear   = 1'b0;
		feed.cand   = 1'b0;
		feed.dirty  = marks_rd_q.dirty;
		feed.key    = eff_stamp;
		case (state_q)
			ST_CLEAR: begin
				mark_we   = 1'b1;
				mark_addr = scan_q[IDX_W-1:0];
			end
			ST_IDLE: begin
				rd_addr = IDX_W'(cmd.block);
			end
			ST_LOOK: begin
				sel_clear = 1'b1;
				mark_addr = blk_q;
				if (!bad_q && kind_q != KIND_MISS && marks_rd_q.valid) begin
					mark_we          = 1'b1;
					mark_wdata.valid = 1'b1;
					mark_wdata.accessed = 1'b1;
					mark_wdata.dirty = marks_rd_q.dirty || (kind_q == KIND_WRITE);
				end
			end
			ST_SCAN: begin
				if (pv_s1) begin
					mark_we          = 1'b1;
					mark_wdata.valid = marks_rd_q.valid;
					mark_wdata.dirty = marks_rd_q.dirty;
					stamp_we         = touched;
					feed.cand        = marks_rd_q.valid && (32'(idx_s1) != 32'(pinned_q));
				end
			end
			ST_EVICT: begin
				mark_addr = best_idx;
				mark_we   = (resident_q >= capacity_q) && sel.found;
			end
			ST_LOAD: begin
				mark_we          = 1'b1;
				mark_addr        = blk_q;
				mark_wdata.valid = 1'b1;
				stamp_we         = 1'b1;
				stamp_addr       = blk_q;
				stamp_wdata      = cnt_q + 32'd1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mark_we) marks_mem[mark_addr] <= mark_wdata;
		if (stamp_we) stamp_mem[stamp_addr] <= stamp_wdata;
		marks_rd_q <= marks_mem[rd_addr];
		stamp_rd_q <= stamp_mem[rd_addr];
	end

	bclru_minsel #(
		.IDX_W(IDX_W)
	) u_minsel (
		.clk     (clk),
		.arst_n  (arst_n),
		.clear   (sel_clear),
		.feed    (feed),
		.feed_idx(idx_s1),
		.sel     (sel),
		.best_idx(best_idx)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			scan_q     <= '0;
			pv_s1      <= 1'b0;
			ev_q       <= 1'b0;
			resident_q <= '0;
			cnt_q      <= '0;
			done_q     <= 1'b0;
		end else begin
			state_q <= state_d;
			pv_s1   <= issue;
			done_q  <= 1'b0;
			case (state_q)
				ST_CLEAR: scan_q <= scan_q + SCAN_W'(1);
				ST_LOOK: begin
					scan_q <= '0;
					if (bad_q || kind_q != KIND_MISS || marks_rd_q.valid) begin
						done_q <= 1'b1;
					end
				end
				ST_SCAN: if (issue) scan_q <= scan_q + SCAN_W'(1);
				ST_EVICT: ev_q <= (resident_q >= capacity_q) && sel.found;
				ST_LOAD: begin
					cnt_q  <= cnt_q + 32'd1;
					done_q <= 1'b1;
					if (!ev_q) resident_q <= resident_q + CNT_W'(1);
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q <= cmd.kind;
			blk_q  <= IDX_W'(cmd.block);
			bad_q  <= bad_in;
		end
		idx_s1 <= scan_q[IDX_W-1:0];
		if (state_q == ST_LOOK) begin
			result_q.evicted_block <= '0;
			result_q.evicted_dirty <= 1'b0;
			if (bad_q) begin
				result_q.status <= STAT_BAD_BLOCK;
			end else if (kind_q != KIND_MISS) begin
				result_q.status <= marks_rd_q.valid ? STAT_NOTED : STAT_ABSENT;
			end else begin
				result_q.status <= STAT_RESIDENT;
			end
		end else if (state_q == ST_LOAD) begin
			result_q.status        <= ev_q ? STAT_LOADED_EVICT : STAT_LOADED;
			result_q.evicted_block <= ev_q ? BLK_W'(best_idx) : '0;
			result_q.evicted_dirty <= ev_q && sel.dirty;
		end
	end

	assign done              = done_q;
	assign result.status        = result_q.status;
	assign result.evicted_block = result_q.evicted_block;
	assign result.evicted_dirty = result_q.evicted_dirty;
	assign result.miss_count    = cnt_q;

	a_done_source: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ($past(state_q) == ST_LOOK || $past(state_q) == ST_LOAD))
		else $error("result strobe without a finishing step");

	a_evict_after_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EVICT) |-> ($past(state_q) == ST_SCAN && !pv_s1))
		else $error("eviction before scan drained");

	a_resident_grow: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_LOAD && !ev_q) |=> (resident_q == $past(resident_q) + CNT_W'(1)))
		else $error("resident count not advanced on load");

	a_evict_status: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.status == STAT_LOADED_EVICT) |-> $past(ev_q))
		else $error("eviction reported without victim");

endmodule

>>> test/bclru_checker.sv
// ---------------------------------------------------------------------------
// bclru_checker
// Watches the command, result and register ports of the block cache
// replacer. It keeps its own copy of the marks, stamps and registers, works
// out the result of every accepted command, and compares each returned
// result field by field with the oldest outcome still awaited.
// ---------------------------------------------------------------------------
module bclru_checker #(
	parameter int NUM_BLOCKS = bclru_pkg::DEF_NUM_BLOCKS
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic                        busy,
	input  bclru_pkg::bclru_cmd_t       cmd,
	input  logic                        done,
	input  bclru_pkg::bclru_result_t    result,
	input  logic                        wr_en,
	input  logic [1:0]                  wr_index,
	input  logic [bclru_pkg::CNT_W-1:0] wr_data,
	output int                          fail_count,
	output int                          open_count,
	output int                          evict_count
);
	timeunit 1ns;
	timeprecision 1ps;

	import bclru_pkg::*;

	logic [CNT_W-1:0]   capacity_q;
	logic [BLK_W-1:0]   pinned_q;
	logic [CNT_W-1:0]   blocks_q;
	bit                 resident_mark [NUM_BLOCKS];
	bit                 touched_mark [NUM_BLOCKS];
	bit                 dirty_mark [NUM_BLOCKS];
	logic [STAMP_W-1:0] last_use [NUM_BLOCKS];
	int unsigned        resident_total;
	logic [STAMP_W-1:0] miss_stamp;
	bclru_result_t      awaited_outcomes [$];
	int                 errors = 0;
	int                 evictions = 0;

	task automatic replay_command(input bclru_cmd_t c, output bclru_result_t r);
		int unsigned        b;
		bit                 found;
		int unsigned        victim;
		logic [STAMP_W-1:0] oldest;
		b      = c.block;
		found  = 1'b0;
		victim = 0;
		oldest = '0;
		r      = '0;
		if (c.kind == KIND_BAD || b >= blocks_q || b >= NUM_BLOCKS) begin
			r.status = STAT_BAD_BLOCK;
		end else if (c.kind != KIND_MISS) begin
			if (resident_mark[b]) begin
				touched_mark[b] = 1'b1;
				if (c.kind == KIND_WRITE)
					dirty_mark[b] = 1'b1;
				r.status = STAT_NOTED;
			end else begin
				r.status = STAT_ABSENT;
			end
		end else if (resident_mark[b]) begin
			r.status = STAT_RESIDENT;
		end else begin
			// sample accessed marks into stamps
			for (int i = 0; i < NUM_BLOCKS; i++) begin
				if (resident_mark[i] && touched_mark[i])
					last_use[i] = miss_stamp;
				touched_mark[i] = 1'b0;
			end
			r.status = STAT_LOADED;
			if (resident_total >= capacity_q) begin
				for (int i = 0; i < NUM_BLOCKS; i++) begin
					if (resident_mark[i] && i != pinned_q && (!found || last_use[i] < oldest)) begin
						found  = 1'b1;
						victim = i;
						oldest = last_use[i];
					end
				end
				if (found) begin
					r.status        = STAT_LOADED_EVICT;
					r.evicted_block = victim[BLK_W-1:0];
					r.evicted_dirty = dirty_mark[victim];
					resident_mark[victim] = 1'b0;
					dirty_mark[victim]    = 1'b0;
					resident_total--;
					evictions++;
				end
			end
			miss_stamp       = miss_stamp + 1'b1;
			resident_mark[b] = 1'b1;
			dirty_mark[b]    = 1'b0;
			touched_mark[b]  = 1'b0;
			last_use[b]      = miss_stamp;
			resident_total++;
		end
		r.miss_count = miss_stamp;
	endtask

	always @(posedge clk or negedge arst_n) begin
		bclru_result_t want;
		bclru_result_t got;
		if (!arst_n) begin
			capacity_q     = RST_CAPACITY;
			pinned_q       = RST_PINNED;
			blocks_q       = RST_BLOCKS;
			resident_total = 0;
			miss_stamp     = '0;
			for (int i = 0; i < NUM_BLOCKS; i++) begin
				resident_mark[i] = 1'b0;
				touched_mark[i]  = 1'b0;
				dirty_mark[i]    = 1'b0;
				last_use[i]      = '0;
			end
			awaited_outcomes.delete();
		end else begin
			if (wr_en) begin
				case (wr_index)
					REG_CAPACITY: capacity_q = wr_data;
					REG_PINNED:   pinned_q = wr_data[BLK_W-1:0];
					REG_BLOCKS:   blocks_q = wr_data;
					default: ;
				endcase
			end
			if (done) begin
				got = result;
				if (awaited_outcomes.size() == 0) begin
					$error("result transfer with nothing awaited: status %0d", got.status);
					errors++;
				end else begin
					want = awaited_outcomes.pop_front();
					if (got.status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, got.status);
						errors++;
					end
					if (got.evicted_block !== want.evicted_block) begin
						$error("evicted_block: expected %0d, got %0d",
							want.evicted_block, got.evicted_block);
						errors++;
					end
					if (got.evicted_dirty !== want.evicted_dirty) begin
						$error("evicted_dirty: expected %0d, got %0d",
							want.evicted_dirty, got.evicted_dirty);
						errors++;
					end
					if (got.miss_count !== want.miss_count) begin
						$error("miss_count: expected %0d, got %0d",
							want.miss_count, got.miss_count);
						errors++;
					end
				end
			end
			if (start && !busy) begin
				replay_command(cmd, want);
				awaited_outcomes.push_back(want);
			end
		end
		fail_count  <= errors;
		open_count  <= awaited_outcomes.size();
		evict_count <= evictions;
	end

endmodule

>>> test/block_cache_lru_replacer_tb.sv
// ---------------------------------------------------------------------------
// block_cache_lru_replacer_tb
// Drives read, write and miss commands into the block cache replacer under a
// series of capacity, pinned block and disk size settings: a directed run
// through the corner cases, then random commands drawn mostly from a small
// pool of block numbers so that hits, repeat misses and evictions are common.
// A separate checker predicts and compares every result.
// ---------------------------------------------------------------------------
module block_cache_lru_replacer_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import bclru_pkg::*;

	localparam int LIMIT              = 3_000_000;
	localparam int RANDOM_PER_SETTING = 116;

	typedef struct {
		int capacity;
		int pinned;
		int blocks;
		int base;
		int span;
	} setting_t;

	logic             clk;
	logic             arst_n;
	logic             start;
	logic             busy;
	bclru_cmd_t       cmd;
	logic             done;
	bclru_result_t    result;
	logic             wr_en;
	logic [1:0]       wr_index;
	logic [CNT_W-1:0] wr_data;

	int          fail_count;
	int          open_count;
	int          evict_count;
	int          sent;
	int          loads;
	int          settings_used;
	int unsigned cycle_count = 0;

	bclru_cmd_t opening_cmds [$];
	bclru_cmd_t ordering_cmds [$];
	setting_t   plan [5];

	always #10 clk = ~clk;

	block_cache_lru_replacer uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.cmd      (cmd),
		.done     (done),
		.result   (result),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data)
	);

	bclru_checker watch (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.cmd         (cmd),
		.done        (done),
		.result      (result),
		.wr_en       (wr_en),
		.wr_index    (wr_index),
		.wr_data     (wr_data),
		.fail_count  (fail_count),
		.open_count  (open_count),
		.evict_count (evict_count)
	);

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == LIMIT) begin
			$display("Timeout after %0d cycles", LIMIT);
			$display("Some tests failed");
			$finish;
		end
	end

	function automatic bclru_cmd_t make_cmd(logic [1:0] k, int b);
		bclru_cmd_t c;
		c.kind  = k;
		c.block = b[BLK_W-1:0];
		return c;
	endfunction

	// mostly short gaps, a few long ones
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		else if (r < 85)
			return $urandom_range(1, 3);
		else if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(30, 120);
	endfunction

	task automatic issue(input bclru_cmd_t c, input int gap);
		start <= 1'b1;
		cmd   <= c;
		do @(posedge clk); while (busy);
		sent++;
		if (c.kind == KIND_MISS)
			loads++;
		if (gap > 0) begin
			start <= 1'b0;
			cmd   <= bclru_cmd_t'($urandom_range(0, 4095));
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic settle();
		start <= 1'b0;
		@(posedge clk);
		while (open_count != 0 || busy) @(posedge clk);
	endtask

	task automatic apply_setting(input setting_t s);
		wr_en    <= 1'b1;
		wr_index <= REG_CAPACITY;
		wr_data  <= s.capacity[CNT_W-1:0];
		@(posedge clk);
		wr_index <= REG_PINNED;
		wr_data  <= s.pinned[CNT_W-1:0];
		@(posedge clk);
		wr_index <= REG_BLOCKS;
		wr_data  <= s.blocks[CNT_W-1:0];
		@(posedge clk);
		wr_en <= 1'b0;
		settings_used++;
	endtask

	initial begin
		int         sel;
		bclru_cmd_t c;
		clk           = 1'b0;
		arst_n        = 1'b0;
		start         = 1'b0;
		cmd           = '0;
		wr_en         = 1'b0;
		wr_index      = REG_CAPACITY;
		wr_data       = '0;
		sent          = 0;
		loads         = 0;
		settings_used = 0;

		// capacity 1 with the pinned block alone resident: no victim, then
		// one eviction per miss although the count stays above capacity
		opening_cmds = '{
			make_cmd(KIND_READ, 0), make_cmd(KIND_BAD, 0), make_cmd(KIND_MISS, 1023),
			make_cmd(KIND_MISS, 1), make_cmd(KIND_MISS, 1), make_cmd(KIND_MISS, 0),
			make_cmd(KIND_WRITE, 0), make_cmd(KIND_READ, 1), make_cmd(KIND_MISS, 999),
			make_cmd(KIND_WRITE, 999), make_cmd(KIND_MISS, 512), make_cmd(KIND_READ, 512),
			make_cmd(KIND_MISS, 1000), make_cmd(KIND_WRITE, 1000)
		};
		// recency order with the top block pinned
		ordering_cmds = '{
			make_cmd(KIND_MISS, 2), make_cmd(KIND_READ, 1), make_cmd(KIND_MISS, 3),
			make_cmd(KIND_READ, 512), make_cmd(KIND_WRITE, 2), make_cmd(KIND_MISS, 1023),
			make_cmd(KIND_MISS, 4), make_cmd(KIND_WRITE, 1023)
		};
		plan[0] = '{10, 1, 1024, 0, 16};
		plan[1] = '{1024, 0, 1024, 0, 1024};
		plan[2] = '{1, 1023, 2, 0, 4};
		plan[3] = '{4, 595, 600, 590, 16};
		plan[4] = '{32, 20, 64, 0, 80};

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		apply_setting('{1, 1, 1000, 0, 1});
		foreach (opening_cmds[i])
			issue(opening_cmds[i], pick_gap());
		settle();
		apply_setting('{3, 1023, 1024, 0, 1});
		foreach (ordering_cmds[i])
			issue(ordering_cmds[i], pick_gap());

		foreach (plan[p]) begin
			settle();
			apply_setting(plan[p]);
			for (int n = 0; n < RANDOM_PER_SETTING; n++) begin
				sel = $urandom_range(0, 99);
				c   = make_cmd(KIND_READ, plan[p].base + $urandom_range(0, plan[p].span - 1));
				if (sel < 38)
					c.kind = KIND_MISS;
				else if (sel < 63)
					c.kind = KIND_READ;
				else if (sel < 88)
					c.kind = KIND_WRITE;
				else if (sel < 93)
					c.kind = KIND_BAD;
				else
					c = bclru_cmd_t'($urandom_range(0, 4095));
				issue(c, ((n % 60) < 20) ? 0 : pick_gap());
			end
		end

		settle();
		repeat (DEF_NUM_BLOCKS + 16) @(posedge clk);
		$display("Ran %0d commands (%0d loads) over %0d register settings", sent, loads,
			settings_used);
		$display("Evictions predicted and checked: %0d", evict_count);
		if (fail_count == 0 && open_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

>>> files.f
src/bclru_pkg.sv
src/bclru_minsel.sv
src/block_cache_lru_replacer.sv
test/bclru_checker.sv
test/block_cache_lru_replacer_tb.sv
